[hw/rtl/spnh_pkg.sv]
// Shared types and constants of the shortest-path next-hop table.
`default_nettype none
package spnh_pkg;

  localparam int unsigned WEIGHT_W = 27;
  localparam logic [WEIGHT_W-1:0] NO_LINK = 27'd99999999;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                op;
    logic [3:0]          row;
    logic [3:0]          col;
    logic [WEIGHT_W-1:0] weight;
    logic [3:0]          source;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]          dest;
    logic [WEIGHT_W-1:0] metric;
    logic [3:0]          next_hop;
    logic                is_self;
    logic                last;
  } tbl_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_SEL_DRAIN,
    ST_SEL_CHK,
    ST_RELAX,
    ST_RELAX_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_DATA,
    ST_WALK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/spnh_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module spnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/spnh_alu.sv]
// Shared saturating adder and less-than comparator.
`default_nettype none
module spnh_alu (
  input  wire logic [spnh_pkg::WEIGHT_W-1:0] a,
  input  wire logic [spnh_pkg::WEIGHT_W-1:0] b,
  input  wire logic [spnh_pkg::WEIGHT_W-1:0] c,
  input  wire logic                          add_en,
  output logic      [spnh_pkg::WEIGHT_W-1:0] sum,
  output logic                               lt
);
  import spnh_pkg::*;

  logic [WEIGHT_W:0] raw;

  always_comb begin
    raw = {1'b0, a} + (add_en ? {1'b0, b} : '0);
    sum = (raw > {1'b0, NO_LINK}) ? NO_LINK : raw[WEIGHT_W-1:0];
    lt  = sum < c;
  end

endmodule
`default_nettype wire

[hw/rtl/shortest_path_next_hop_table.sv]
// Shortest-path next-hop table: weight matrix, Dijkstra sequencer, row output.
//
// cmd channel (cmd_valid/cmd_stall/cmd): op OP_WRITE stores one link weight;
// op OP_COMPUTE runs the search from cmd.source over the first n_eff nodes
// (node_count clamped to 1..MAX_NODES) and then sends one tbl item per
// destination, in order, with last set on the final row.
// Each settle round scans the cost RAM once for selection and once for
// relaxation through its single read port, with one saturating add/compare
// unit doing the cost additions and less-than compares.
// cmd_stall stays high from a compute's acceptance until its last row has
// entered the output register.
// tbl is a registered output: while tbl_stall is high the row holds and the
// sequencer waits before producing the next row.
// Reset (rst, synchronous) returns node_count to 16, empties the output and
// clears search state; the weight matrix holds no defined value until written.
// The user writes node_count at APB address 0 only while idle; not enforced.
`default_nettype none
module shortest_path_next_hop_table #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire spnh_pkg::cmd_item_t  cmd,
  output logic                      tbl_valid,
  input  wire logic                 tbl_stall,
  output spnh_pkg::tbl_item_t       tbl,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  import spnh_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int DW  = NW + WEIGHT_W;

  state_t state, state_next;

  logic [4:0]           node_count;
  logic [NCW-1:0]       n_eff;
  logic [NW-1:0]        nm1;
  logic [NW-1:0]        ctr;
  logic [NW-1:0]        src_idx;
  logic                 src_ok;
  logic [NW-1:0]        best_idx;
  logic [WEIGHT_W-1:0]  best_dist;
  logic                 best_valid;
  logic [MAX_NODES-1:0] touched;
  logic [MAX_NODES-1:0] settled;
  logic                 pv;
  logic [NW-1:0]        pidx;
  logic [WEIGHT_W-1:0]  metric_r;
  logic [NW-1:0]        hop_r;

  logic                 cmd_acc;
  logic                 src_ok_in;
  logic                 row_ok;
  logic                 tbl_load;

  logic                 dwe;
  logic [NW-1:0]        dwaddr;
  logic [DW-1:0]        dwdata;
  logic [NW-1:0]        draddr;
  logic [DW-1:0]        drdata;
  logic [WEIGHT_W-1:0]  dist_rd;
  logic [NW-1:0]        pred_rd;

  logic                 wwe;
  logic [2*NW-1:0]      wwaddr;
  logic [WEIGHT_W-1:0]  wwdata;
  logic [2*NW-1:0]      wraddr;
  logic [WEIGHT_W-1:0]  wrdata;

  logic                 relax_mode;
  logic [WEIGHT_W-1:0]  alu_a, alu_c, alu_sum;
  logic                 alu_lt;
  logic                 sel_take;
  logic                 relax_upd;
  logic                 is_self_d;

  spnh_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_cost_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .raddr (draddr),
    .rdata (drdata)
  );

  spnh_ram #(.WIDTH(WEIGHT_W), .DEPTH(2 ** (2 * NW))) u_weight_ram (
    .clk   (clk),
    .we    (wwe),
    .waddr (wwaddr),
    .wdata (wwdata),
    .raddr (wraddr),
    .rdata (wrdata)
  );

  spnh_alu u_alu (
    .a      (alu_a),
    .b      (wrdata),
    .c      (alu_c),
    .add_en (relax_mode),
    .sum    (alu_sum),
    .lt     (alu_lt)
  );

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {27'b0, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 5'd16;
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
      node_count <= pwdata[4:0];
    end
  end

  always_comb begin
    if (node_count == 5'd0) begin
      n_eff = NCW'(1);
    end else if ({27'b0, node_count} > 32'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(node_count);
    end
    nm1 = NW'(n_eff - NCW'(1));
  end

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign src_ok_in = {28'b0, cmd.source} < 32'(n_eff);
  assign row_ok    = ({28'b0, cmd.row} < 32'(MAX_NODES)) &&
                     ({28'b0, cmd.col} < 32'(MAX_NODES));
  assign tbl_load  = (state == ST_OUT) && (!tbl_valid || !tbl_stall);

  assign dist_rd    = touched[pidx] ? drdata[WEIGHT_W-1:0] : NO_LINK;
  assign pred_rd    = drdata[DW-1:WEIGHT_W];
  assign relax_mode = (state == ST_RELAX) || (state == ST_RELAX_DRAIN);
  assign alu_a      = relax_mode ? best_dist : dist_rd;
  assign alu_c      = relax_mode ? dist_rd : best_dist;
  assign sel_take   = pv && !relax_mode && !settled[pidx] && (!best_valid || alu_lt);
  assign relax_upd  = pv && relax_mode && (wrdata < NO_LINK) && alu_lt;
  assign is_self_d  = src_ok && (ctr == src_idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc && cmd.op == OP_COMPUTE) begin
          state_next = src_ok_in ? ST_SEL : ST_EMIT_RD;
        end
      end
      ST_SEL:         if (ctr == nm1) state_next = ST_SEL_DRAIN;
      ST_SEL_DRAIN:   state_next = ST_SEL_CHK;
      ST_SEL_CHK: begin
        state_next = (!best_valid || best_dist == NO_LINK) ? ST_EMIT_RD : ST_RELAX;
      end
      ST_RELAX:       if (ctr == nm1) state_next = ST_RELAX_DRAIN;
      ST_RELAX_DRAIN: state_next = ST_SEL;
      ST_EMIT_RD:     state_next = ST_EMIT_DATA;
      ST_EMIT_DATA: begin
        if (is_self_d || !touched[pidx] || pred_rd == src_idx) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK:        if (pred_rd == src_idx) state_next = ST_OUT;
      ST_OUT: begin
        if (tbl_load) begin
          state_next = (ctr == nm1) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    dwe    = 1'b0;
    dwaddr = pidx;
    dwdata = {best_idx, alu_sum};
    draddr = ctr;
    wwe    = 1'b0;
    wwaddr = {NW'(cmd.row), NW'(cmd.col)};
    wwdata = (cmd.weight > NO_LINK) ? NO_LINK : cmd.weight;
    wraddr = {best_idx, ctr};
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc && cmd.op == OP_WRITE) begin
          wwe = row_ok;
        end
        if (cmd_acc && cmd.op == OP_COMPUTE) begin
          dwe    = src_ok_in;
          dwaddr = NW'(cmd.source);
          dwdata = '0;
        end
      end
      ST_RELAX, ST_RELAX_DRAIN: dwe = relax_upd;
      ST_EMIT_DATA, ST_WALK:   draddr = pred_rd;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      touched   <= '0;
      settled   <= '0;
      pv        <= 1'b0;
      tbl_valid <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= (state == ST_SEL) || (state == ST_RELAX);
      if (tbl_load) begin
        tbl_valid <= 1'b1;
      end else if (!tbl_stall) begin
        tbl_valid <= 1'b0;
      end
      if (state == ST_IDLE && cmd_acc && cmd.op == OP_COMPUTE) begin
        settled <= '0;
        touched <= src_ok_in ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << NW'(cmd.source)) : '0;
      end
      if (relax_upd) begin
        touched[pidx] <= 1'b1;
      end
      if (state == ST_SEL_CHK && best_valid && best_dist != NO_LINK) begin
        settled[best_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= draddr;
    unique case (state)
      ST_IDLE: begin
        ctr        <= '0;
        best_valid <= 1'b0;
        src_idx    <= NW'(cmd.source);
        src_ok     <= src_ok_in;
      end
      ST_SEL, ST_SEL_DRAIN: begin
        if (state == ST_SEL) begin
          ctr <= (ctr == nm1) ? '0 : ctr + NW'(1);
        end
        if (sel_take) begin
          best_valid <= 1'b1;
          best_dist  <= dist_rd;
          best_idx   <= pidx;
        end
      end
      ST_SEL_CHK: ctr <= '0;
      ST_RELAX:   ctr <= (ctr == nm1) ? '0 : ctr + NW'(1);
      ST_RELAX_DRAIN: begin
        ctr        <= '0;
        best_valid <= 1'b0;
      end
      ST_EMIT_RD: ;
      ST_EMIT_DATA: begin
        metric_r <= dist_rd;
        hop_r    <= ctr;
      end
      ST_WALK: hop_r <= pidx;
      ST_OUT: begin
        if (tbl_load) begin
          ctr <= ctr + NW'(1);
        end
      end
      default: ;
    endcase
    if (tbl_load) begin
      tbl.dest     <= 4'(ctr);
      tbl.metric   <= metric_r;
      tbl.next_hop <= 4'(hop_r);
      tbl.is_self  <= is_self_d;
      tbl.last     <= (ctr == nm1);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/spnh_chk.sv]
// Port-level assertions for the shortest-path next-hop table, with bind.
`default_nettype none
module spnh_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                cmd_valid,
  input wire logic                cmd_stall,
  input wire spnh_pkg::cmd_item_t cmd,
  input wire logic                tbl_valid,
  input wire logic                tbl_stall,
  input wire spnh_pkg::tbl_item_t tbl
);
  import spnh_pkg::*;

  a_tbl_hold: assert property (@(posedge clk) disable iff (rst)
    (tbl_valid && tbl_stall) |=> (tbl_valid && $stable(tbl)))
    else $error("tbl item changed while stalled");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.op == OP_COMPUTE) |=> cmd_stall)
    else $error("compute did not hold off the next item");

  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.op == OP_WRITE) |=> !cmd_stall)
    else $error("weight write left the block busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!tbl_valid && !cmd_stall))
    else $error("block not empty after reset");

endmodule

bind shortest_path_next_hop_table spnh_chk u_spnh_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .tbl_valid (tbl_valid),
  .tbl_stall (tbl_stall),
  .tbl       (tbl)
);
`default_nettype wire

[tb/shortest_path_next_hop_table_test.sv]
// Self-checking testbench: routing-table predictor, random graphs, backpressure.
`timescale 1ns / 1ps
module shortest_path_next_hop_table_test;
  import spnh_pkg::*;

  localparam int MAX_NODES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] NODE_COUNT_ADDR = 3'(4 * int'(REG_NODE_COUNT));

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_item_t cmd;
  logic tbl_valid;
  logic tbl_stall;
  tbl_item_t tbl;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [WEIGHT_W-1:0] link_cost [MAX_NODES][MAX_NODES];
  bit link_known [MAX_NODES][MAX_NODES];
  logic [4:0] node_count_reg;
  tbl_item_t expected_rows[$];
  tbl_item_t oldest_row;
  int mismatches = 0;
  int cycle_count = 0;
  logic hold_rows;
  logic steady;

  shortest_path_next_hop_table #(.MAX_NODES(MAX_NODES)) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .tbl_valid(tbl_valid),
    .tbl_stall(tbl_stall),
    .tbl(tbl),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Row checker and receiver stall.
  always @(posedge clk) begin
    if (!rst && tbl_valid === 1'b1 && tbl_stall === 1'b0) begin
      if (expected_rows.size() == 0) begin
        note_mismatch($sformatf("unexpected row dest=%0d", tbl.dest));
      end else begin
        oldest_row = expected_rows.pop_front();
        if (tbl.dest !== oldest_row.dest)
          note_mismatch($sformatf("dest got %0d want %0d", tbl.dest, oldest_row.dest));
        if (tbl.metric !== oldest_row.metric)
          note_mismatch($sformatf("dest %0d metric got %0d want %0d",
                                  oldest_row.dest, tbl.metric, oldest_row.metric));
        if (tbl.next_hop !== oldest_row.next_hop)
          note_mismatch($sformatf("dest %0d next_hop got %0d want %0d",
                                  oldest_row.dest, tbl.next_hop, oldest_row.next_hop));
        if (tbl.is_self !== oldest_row.is_self)
          note_mismatch($sformatf("dest %0d is_self got %0b want %0b",
                                  oldest_row.dest, tbl.is_self, oldest_row.is_self));
        if (tbl.last !== oldest_row.last)
          note_mismatch($sformatf("dest %0d last got %0b want %0b",
                                  oldest_row.dest, tbl.last, oldest_row.last));
      end
    end
    tbl_stall <= hold_rows || (!steady && $urandom_range(99) < 13);
  end

  function automatic int used_nodes();
    if (node_count_reg == 5'd0) return 1;
    if (node_count_reg > 5'(MAX_NODES)) return MAX_NODES;
    return int'(node_count_reg);
  endfunction

  function automatic void store_weight(input logic [3:0] r, input logic [3:0] c,
                                       input logic [WEIGHT_W-1:0] w);
    link_cost[r][c] = (w > NO_LINK) ? NO_LINK : w;
    link_known[r][c] = 1'b1;
  endfunction

  // Dijkstra from src over the active nodes, one expected row per destination.
  function automatic void predict_routes(input logic [3:0] src);
    int unsigned cost [MAX_NODES];
    int hop_back [MAX_NODES];
    bit done [MAX_NODES];
    int n;
    int best;
    int cur;
    int unsigned sum;
    tbl_item_t row;
    n = used_nodes();
    for (int i = 0; i < MAX_NODES; i++) begin
      cost[i] = NO_LINK;
      hop_back[i] = -1;
      done[i] = 1'b0;
    end
    if (int'(src) < n) begin
      cost[src] = 0;
      for (int round = 0; round < n; round++) begin
        best = -1;
        for (int j = 0; j < n; j++) begin
          if (!done[j] && (best < 0 || cost[j] < cost[best])) best = j;
        end
        if (best < 0 || cost[best] == NO_LINK) break;
        done[best] = 1'b1;
        for (int v = 0; v < n; v++) begin
          if (link_cost[best][v] < NO_LINK) begin
            sum = cost[best] + link_cost[best][v];
            if (sum > NO_LINK) sum = NO_LINK;
            if (sum < cost[v]) begin
              cost[v] = sum;
              hop_back[v] = best;
            end
          end
        end
      end
    end
    for (int d = 0; d < n; d++) begin
      row.dest = 4'(d);
      row.metric = WEIGHT_W'(cost[d]);
      row.is_self = (d == int'(src));
      row.last = (d == n - 1);
      cur = d;
      if (!row.is_self) begin
        for (int steps = 0; steps < MAX_NODES; steps++) begin
          if (hop_back[cur] < 0 || hop_back[cur] == int'(src)) break;
          cur = hop_back[cur];
        end
      end
      row.next_hop = 4'(cur);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0, 1, 2, 3: return WEIGHT_W'($urandom_range(20));
      4, 5: return NO_LINK;
      6: return WEIGHT_W'($urandom_range(99999999));
      7: return NO_LINK - WEIGHT_W'($urandom_range(3, 1));
      8: return WEIGHT_W'($urandom());
      default: return WEIGHT_W'($urandom_range(134217727, 100000000));
    endcase
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t item;
    item.op = $urandom_range(1);
    item.row = $urandom_range(15);
    item.col = $urandom_range(15);
    item.weight = WEIGHT_W'($urandom());
    item.source = $urandom_range(15);
    return item;
  endfunction

  task automatic send_cmd(input cmd_item_t item);
    while (!steady && $urandom_range(99) < 13) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    if (item.op == OP_WRITE) store_weight(item.row, item.col, item.weight);
    else predict_routes(item.source);
  endtask

  task automatic write_link(input int r, input int c, input logic [WEIGHT_W-1:0] w);
    cmd_item_t item;
    item = random_item();
    item.op = OP_WRITE;
    item.row = 4'(r);
    item.col = 4'(c);
    item.weight = w;
    send_cmd(item);
  endtask

  task automatic compute_from(input int src);
    cmd_item_t item;
    item = random_item();
    item.op = OP_COMPUTE;
    item.source = 4'(src);
    send_cmd(item);
  endtask

  // Every weight a compute over n nodes may read gets written first.
  task automatic cover_matrix(input int n, input bit random_fill);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!link_known[r][c]) write_link(r, c, random_fill ? pick_weight() : NO_LINK);
      end
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_node_count();
    logic [31:0] value;
    apb_read(NODE_COUNT_ADDR, value);
    if (value !== {27'd0, node_count_reg})
      note_mismatch($sformatf("node_count read %0d want %0d", value, node_count_reg));
  endtask

  task automatic set_node_count(input logic [4:0] count);
    wait_drained();
    apb_write(NODE_COUNT_ADDR, ($urandom() & ~32'h1f) | 32'(count));
    node_count_reg = count;
    check_node_count();
  endtask

  task automatic test_reset_value();
    check_node_count();
  endtask

  task automatic test_single_node();
    set_node_count(5'd1);
    write_link(0, 0, 27'd5);
    compute_from(0);
    compute_from(15);
  endtask

  task automatic test_count_zero();
    set_node_count(5'd0);
    compute_from(0);
    compute_from(1);
  endtask

  // Tie on equal paths, oversized weight, saturating sum, zero weight.
  task automatic test_small_graph();
    set_node_count(5'd4);
    write_link(0, 0, 27'd0);
    write_link(0, 1, 27'd3);
    write_link(1, 2, 27'd4);
    write_link(0, 2, 27'd7);
    write_link(2, 3, 27'h7ffffff);
    write_link(1, 3, NO_LINK - 27'd1);
    write_link(3, 0, 27'd0);
    cover_matrix(4, 1'b0);
    compute_from(0);
    compute_from(3);
    compute_from(1);
  endtask

  // Receiver holds off while alternating computes and writes wait behind the output.
  task automatic test_backpressure();
    set_node_count(5'd4);
    cover_matrix(4, 1'b1);
    fork
      begin
        hold_rows <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rows <= 1'b0;
      end
    join_none
    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0) compute_from($urandom_range(3));
      else write_link($urandom_range(3), $urandom_range(3), pick_weight());
    end
    wait_drained();
  endtask

  task automatic run_phase(input logic [4:0] count, input int items, input bit calm);
    cmd_item_t item;
    int n;
    int kind;
    set_node_count(count);
    n = used_nodes();
    steady <= calm;
    cover_matrix(n, 1'b1);
    for (int k = 0; k < items; k++) begin
      item = random_item();
      kind = $urandom_range(99);
      if (kind < 55) begin
        item.op = OP_WRITE;
        item.row = $urandom_range(n - 1);
        item.col = $urandom_range(n - 1);
        item.weight = pick_weight();
      end else if (kind < 85) begin
        item.op = OP_COMPUTE;
        item.source = $urandom_range(n - 1);
      end else if (kind < 92) begin
        item.op = OP_COMPUTE;
      end else begin
        item.op = OP_WRITE;
      end
      send_cmd(item);
      if ($urandom_range(99) < 4) wait_drained();
    end
    steady <= 1'b0;
  endtask

  task automatic test_random_graphs();
    logic [4:0] counts [11];
    int lengths [11];
    bit calm [11];
    counts = '{5'd3, 5'd5, 5'd1, 5'd8, 5'd2, 5'd0, 5'd6, 5'd16, 5'd31, 5'd17, 5'd4};
    lengths = '{25, 25, 10, 25, 15, 8, 25, 20, 12, 10, 25};
    calm = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
    for (int p = 0; p < 11; p++) run_phase(counts[p], lengths[p], calm[p]);
  endtask

  initial begin
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    tbl_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_rows <= 1'b0;
    steady <= 1'b0;
    node_count_reg = 5'd16;
    for (int r = 0; r < MAX_NODES; r++) begin
      for (int c = 0; c < MAX_NODES; c++) begin
        link_cost[r][c] = '0;
        link_known[r][c] = 1'b0;
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_single_node();
    test_count_zero();
    test_small_graph();
    test_backpressure();
    test_random_graphs();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/spnh_pkg.sv
hw/rtl/spnh_ram.sv
hw/rtl/spnh_alu.sv
hw/rtl/shortest_path_next_hop_table.sv
hw/rtl/spnh_chk.sv
tb/shortest_path_next_hop_table_test.sv
